/* rtl/cpp_pkg.sv */
// Shared widths and helpers for the camera perspective projection unit.
// No dependencies.
package cpp_pkg;

    localparam int W_IN   = 32;              // Q16.16 input words
    localparam int W_TRIG = 16;              // Q2.14 trig words
    localparam int W_C    = 40;              // rotated coordinates
    localparam int W_P    = W_C + W_TRIG;    // rotation products
    localparam int W_S    = W_P + 1;         // product sums
    localparam int W_N    = 48;              // numerator x*200
    localparam int W_D    = W_C;             // depth divisor
    localparam int NDIV   = 17;              // quotient bits kept
    localparam int W_R    = W_D + NDIV;      // divider compare width
    localparam int FRAC   = 14;
    localparam int ROUND_BIAS = 8192;
    localparam int DEPTH_OFS  = 5 * 65536;
    localparam logic signed [8:0] PERSP = 9'sd200;

    localparam int REG_CAM_X  = 0;
    localparam int REG_CAM_Y  = 1;
    localparam int REG_CAM_Z  = 2;
    localparam int REG_ROT_X  = 3;
    localparam int REG_ROT_Y  = 4;
    localparam int REG_ROT_Z  = 5;
    localparam int REG_WIN_X  = 6;
    localparam int REG_WIN_Y  = 7;
    localparam int NUM_REGS   = 8;

    typedef struct packed {
        logic sgn_x;
        logic sgn_y;
        logic ovf_x;
        logic ovf_y;
        logic dz;
        logic win;
    } t_side;

    // rounded Q16.16 result of a +/- b, with a and b in Q.30
    function automatic logic signed [W_C-1:0] rot_sum(
        input logic signed [W_P-1:0] a,
        input logic signed [W_P-1:0] b,
        input logic                  sub
    );
        logic signed [W_S-1:0] s;
        s = sub ? (W_S'(a) - W_S'(b)) : (W_S'(a) + W_S'(b));
        s = s + W_S'(ROUND_BIAS);
        return W_C'(s >>> FRAC);
    endfunction

endpackage

/* rtl/camera_perspective_project_unit.sv */
// Camera perspective projection unit: translate, rotate X/Y/Z, project, saturate.
// Depends on cpp_pkg.
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_point_x, i_point_y, i_point_z
// out       output     o_out_valid / i_out_ready o_screen_x, o_screen_y, o_in_window,
//                                                o_depth_invalid, o_clipped
// cfg       input      APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One item per cycle unless the output stalls; 28 register stages, o_out_valid is the last stage's valid bit.
// Stages: translate 1, three rotations of multiply then round-sum 6, scale and depth 1,
// magnitude 1, divider setup 1, restoring divider 17 (one quotient bit each), saturate 1.
// Synchronous reset clears valid bits and loads register reset values.
// A stall on the output freezes the whole pipeline; nothing is lost.
module camera_perspective_project_unit #(
    parameter int SCREEN_CENTER_X  = 400,
    parameter int SCREEN_CENTER_Y  = 300,
    parameter int WINDOW_HALF_SIZE = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_screen_x,
    output logic [15:0] o_screen_y,
    output logic        o_in_window,
    output logic        o_depth_invalid,
    output logic        o_clipped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NST = 28;
    localparam int WV  = cpp_pkg::NDIV + 2;
    localparam logic signed [33:0] HALF = 34'(WINDOW_HALF_SIZE * 65536);

    logic [31:0] r_cfg [0:cpp_pkg::NUM_REGS-1];
    logic [NST-1:0] r_vld;
    logic en;

    assign pready = 1'b1;
    assign prdata = r_cfg[paddr[4:2]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[cpp_pkg::REG_CAM_X] <= 32'h0;
            r_cfg[cpp_pkg::REG_CAM_Y] <= 32'h0;
            r_cfg[cpp_pkg::REG_CAM_Z] <= 32'hFFF6_0000;
            r_cfg[cpp_pkg::REG_ROT_X] <= 32'h4000_0000;
            r_cfg[cpp_pkg::REG_ROT_Y] <= 32'h4000_0000;
            r_cfg[cpp_pkg::REG_ROT_Z] <= 32'h4000_0000;
            r_cfg[cpp_pkg::REG_WIN_X] <= 32'h0;
            r_cfg[cpp_pkg::REG_WIN_Y] <= 32'h0;
        end else if (psel && penable && pwrite) begin
            r_cfg[paddr[4:2]] <= pwdata;
        end
    end

    assign en          = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // trig words
    logic signed [15:0] cx, sx, cy, sy, cz, sz;
    assign cx = $signed(r_cfg[cpp_pkg::REG_ROT_X][31:16]);
    assign sx = $signed(r_cfg[cpp_pkg::REG_ROT_X][15:0]);
    assign cy = $signed(r_cfg[cpp_pkg::REG_ROT_Y][31:16]);
    assign sy = $signed(r_cfg[cpp_pkg::REG_ROT_Y][15:0]);
    assign cz = $signed(r_cfg[cpp_pkg::REG_ROT_Z][31:16]);
    assign sz = $signed(r_cfg[cpp_pkg::REG_ROT_Z][15:0]);

    // translation and window test
    logic signed [32:0] tx, ty, tz;
    logic signed [33:0] wx, wy, wcx, wcy;
    logic win;
    assign tx  = $signed({i_point_x[31], i_point_x})
               - $signed({r_cfg[cpp_pkg::REG_CAM_X][31], r_cfg[cpp_pkg::REG_CAM_X]});
    assign ty  = $signed({i_point_y[31], i_point_y})
               - $signed({r_cfg[cpp_pkg::REG_CAM_Y][31], r_cfg[cpp_pkg::REG_CAM_Y]});
    assign tz  = $signed({i_point_z[31], i_point_z})
               - $signed({r_cfg[cpp_pkg::REG_CAM_Z][31], r_cfg[cpp_pkg::REG_CAM_Z]});
    assign wx  = 34'($signed(i_point_x));
    assign wy  = 34'($signed(i_point_y));
    assign wcx = 34'($signed(r_cfg[cpp_pkg::REG_WIN_X]));
    assign wcy = 34'($signed(r_cfg[cpp_pkg::REG_WIN_Y]));
    assign win = (wx >= wcx - HALF) && (wx <= wcx + HALF)
              && (wy >= wcy - HALF) && (wy <= wcy + HALF);

    logic signed [cpp_pkg::W_C-1:0] r1_x, r1_y, r1_z;
    logic signed [cpp_pkg::W_P-1:0] r2_p0, r2_p1, r2_p2, r2_p3;
    logic signed [cpp_pkg::W_C-1:0] r2_x;
    logic signed [cpp_pkg::W_C-1:0] r3_x, r3_y, r3_z;
    logic signed [cpp_pkg::W_P-1:0] r4_p0, r4_p1, r4_p2, r4_p3;
    logic signed [cpp_pkg::W_C-1:0] r4_y;
    logic signed [cpp_pkg::W_C-1:0] r5_x, r5_y, r5_z;
    logic signed [cpp_pkg::W_P-1:0] r6_p0, r6_p1, r6_p2, r6_p3;
    logic signed [cpp_pkg::W_C-1:0] r6_z;
    logic signed [cpp_pkg::W_C-1:0] r7_x, r7_y, r7_z;
    logic signed [cpp_pkg::W_N-1:0] r8_nx, r8_ny;
    logic signed [cpp_pkg::W_D-1:0] r8_d;
    logic [cpp_pkg::W_N-1:0] r9_anx, r9_any;
    logic [cpp_pkg::W_D-1:0] r9_ad;
    logic r9_sx, r9_sy, r9_dz;
    logic [8:0] r_win;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x <= cpp_pkg::W_C'(tx);
            r1_y <= cpp_pkg::W_C'(ty);
            r1_z <= cpp_pkg::W_C'(tz);
            r_win <= {r_win[7:0], win};
            // about X
            r2_p0 <= r1_y * cx;
            r2_p1 <= r1_z * sx;
            r2_p2 <= r1_y * sx;
            r2_p3 <= r1_z * cx;
            r2_x  <= r1_x;
            r3_y  <= cpp_pkg::rot_sum(r2_p0, r2_p1, 1'b1);
            r3_z  <= cpp_pkg::rot_sum(r2_p2, r2_p3, 1'b0);
            r3_x  <= r2_x;
            // about Y
            r4_p0 <= r3_x * cy;
            r4_p1 <= r3_z * sy;
            r4_p2 <= r3_x * sy;
            r4_p3 <= r3_z * cy;
            r4_y  <= r3_y;
            r5_x  <= cpp_pkg::rot_sum(r4_p0, r4_p1, 1'b1);
            r5_z  <= cpp_pkg::rot_sum(r4_p2, r4_p3, 1'b0);
            r5_y  <= r4_y;
            // about Z
            r6_p0 <= r5_x * cz;
            r6_p1 <= r5_y * sz;
            r6_p2 <= r5_x * sz;
            r6_p3 <= r5_y * cz;
            r6_z  <= r5_z;
            r7_x  <= cpp_pkg::rot_sum(r6_p0, r6_p1, 1'b1);
            r7_y  <= cpp_pkg::rot_sum(r6_p2, r6_p3, 1'b0);
            r7_z  <= r6_z;
            // perspective operands
            r8_nx <= r7_x * cpp_pkg::PERSP;
            r8_ny <= r7_y * cpp_pkg::PERSP;
            r8_d  <= r7_z + cpp_pkg::W_D'(cpp_pkg::DEPTH_OFS);
            r9_anx <= r8_nx[cpp_pkg::W_N-1] ? cpp_pkg::W_N'(-r8_nx) : cpp_pkg::W_N'(r8_nx);
            r9_any <= r8_ny[cpp_pkg::W_N-1] ? cpp_pkg::W_N'(-r8_ny) : cpp_pkg::W_N'(r8_ny);
            r9_ad  <= r8_d[cpp_pkg::W_D-1] ? cpp_pkg::W_D'(-r8_d) : cpp_pkg::W_D'(r8_d);
            r9_sx  <= r8_nx[cpp_pkg::W_N-1] ^ r8_d[cpp_pkg::W_D-1];
            r9_sy  <= r8_ny[cpp_pkg::W_N-1] ^ r8_d[cpp_pkg::W_D-1];
            r9_dz  <= (r8_d == '0);
        end
    end

    // restoring divider, one quotient bit per stage
    logic [cpp_pkg::W_N-1:0]  r_rx [0:WV-2];
    logic [cpp_pkg::W_N-1:0]  r_ry [0:WV-2];
    logic [cpp_pkg::NDIV-1:0] r_qx [0:WV-2];
    logic [cpp_pkg::NDIV-1:0] r_qy [0:WV-2];
    logic [cpp_pkg::W_D-1:0]  r_dm [0:WV-2];
    cpp_pkg::t_side           r_sd [0:WV-2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0] <= r9_anx;
            r_ry[0] <= r9_any;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_dm[0] <= r9_ad;
            r_sd[0].sgn_x <= r9_sx;
            r_sd[0].sgn_y <= r9_sy;
            r_sd[0].ovf_x <= cpp_pkg::W_R'(r9_anx) >= {r9_ad, {cpp_pkg::NDIV{1'b0}}};
            r_sd[0].ovf_y <= cpp_pkg::W_R'(r9_any) >= {r9_ad, {cpp_pkg::NDIV{1'b0}}};
            r_sd[0].dz    <= r9_dz;
            r_sd[0].win   <= r_win[8];
        end
    end

    for (genvar j = 0; j < cpp_pkg::NDIV; j++) begin : g_div
        localparam int SH = cpp_pkg::NDIV - 1 - j;
        logic [cpp_pkg::W_R-1:0] cand, remx, remy;
        assign cand = cpp_pkg::W_R'(r_dm[j]) << SH;
        assign remx = cpp_pkg::W_R'(r_rx[j]);
        assign remy = cpp_pkg::W_R'(r_ry[j]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (remx >= cand) begin
                    r_rx[j+1] <= cpp_pkg::W_N'(remx - cand);
                    r_qx[j+1] <= r_qx[j] | (cpp_pkg::NDIV'(1) << SH);
                end else begin
                    r_rx[j+1] <= r_rx[j];
                    r_qx[j+1] <= r_qx[j];
                end
                if (remy >= cand) begin
                    r_ry[j+1] <= cpp_pkg::W_N'(remy - cand);
                    r_qy[j+1] <= r_qy[j] | (cpp_pkg::NDIV'(1) << SH);
                end else begin
                    r_ry[j+1] <= r_ry[j];
                    r_qy[j+1] <= r_qy[j];
                end
                r_dm[j+1] <= r_dm[j];
                r_sd[j+1] <= r_sd[j];
            end
        end
    end

    // sign, centre, saturate
    cpp_pkg::t_side sd;
    logic signed [18:0] mx, my, vx, vy;
    logic [15:0] n_sx, n_sy;
    logic n_clip;
    assign sd = r_sd[WV-2];
    assign mx = $signed({2'b00, r_qx[WV-2]});
    assign my = $signed({2'b00, r_qy[WV-2]});
    assign vx = (sd.sgn_x ? -mx : mx) + 19'(SCREEN_CENTER_X);
    assign vy = (sd.sgn_y ? -my : my) + 19'(SCREEN_CENTER_Y);

    always_comb begin
        n_clip = 1'b0;
        if (sd.ovf_x || vx > 19'sd32767 || vx < -19'sd32768) begin
            n_clip = 1'b1;
            n_sx   = (sd.ovf_x ? sd.sgn_x : vx[18]) ? 16'h8000 : 16'h7FFF;
        end else begin
            n_sx = vx[15:0];
        end
        if (sd.ovf_y || vy > 19'sd32767 || vy < -19'sd32768) begin
            n_clip = 1'b1;
            n_sy   = (sd.ovf_y ? sd.sgn_y : vy[18]) ? 16'h8000 : 16'h7FFF;
        end else begin
            n_sy = vy[15:0];
        end
        if (sd.dz) begin
            n_clip = 1'b0;
            n_sx   = 16'(SCREEN_CENTER_X);
            n_sy   = 16'(SCREEN_CENTER_Y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_screen_x      <= n_sx;
            o_screen_y      <= n_sy;
            o_in_window     <= sd.win;
            o_depth_invalid <= sd.dz;
            o_clipped       <= n_clip;
        end
    end

    a_dz_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth_invalid |->
            o_screen_x == 16'(SCREEN_CENTER_X) && o_screen_y == 16'(SCREEN_CENTER_Y)
            && !o_clipped)
        else $error("depth invalid item not centred");

    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |->
            o_screen_x == 16'h7FFF || o_screen_x == 16'h8000 ||
            o_screen_y == 16'h7FFF || o_screen_y == 16'h8000)
        else $error("clipped item not on a rail");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_vld == $past(r_vld))
        else $error("pipeline moved during stall");

endmodule
